// ===== hw/rtl/pt_pkg.sv =====
`timescale 1ns / 1ps
// Package for the piece table editor: operation, status, cell command,
// controller state and edit plan codes. No dependencies.
package pt_pkg;

  localparam int POS_W  = 13;
  localparam int CHAR_W = 8;

  localparam logic BUF_ORIG = 1'b0;
  localparam logic BUF_ADD  = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_INSERT,
    OP_DELETE,
    OP_READ
  } op_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_RANGE,
    ST_FULL,
    ST_REFUSED
  } status_e;

  // Command broadcast to every cell of the entry chain
  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_SHIFT_UP,
    CMD_SHIFT_DOWN,
    CMD_WRITE
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_EXEC,
    S_FETCH,
    S_RESP
  } state_e;

  // Sequence of table edits chosen for one beat
  typedef enum logic [3:0] {
    P_NONE,
    P_LOAD,
    P_APPEND,
    P_FRONT,
    P_SPLIT,
    P_DHEAD,
    P_DTAIL,
    P_DSPLIT,
    P_READ
  } plan_e;

endpackage

// ===== hw/rtl/pt_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [0:DEPTH-1];
  logic [WIDTH-1:0] rd_data_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hw/rtl/pt_cell.sv =====
`timescale 1ns / 1ps
// One cell of the entry chain: holds one table entry, passes the locate
// wave to its upper neighbor and shifts entries on command. Uses pt_pkg.
module pt_cell import pt_pkg::*; #(
  parameter int IDX_W = 6,
  parameter int CNT_W = 7,
  parameter int S_W   = 13,
  parameter int L_W   = 14,
  parameter int INDEX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CNT_W-1:0] count_i,
  input  logic [L_W-1:0]   pos_i,
  input  cmd_e             cmd_op_i,
  input  logic [IDX_W-1:0] cmd_idx_i,
  input  logic             cmd_typ_i,
  input  logic [S_W-1:0]   cmd_start_i,
  input  logic [L_W-1:0]   cmd_len_i,
  input  logic             lo_typ_i,
  input  logic [S_W-1:0]   lo_start_i,
  input  logic [L_W-1:0]   lo_len_i,
  input  logic             hi_typ_i,
  input  logic [S_W-1:0]   hi_start_i,
  input  logic [L_W-1:0]   hi_len_i,
  output logic             typ_o,
  output logic [S_W-1:0]   start_o,
  output logic [L_W-1:0]   len_o,
  input  logic             w_vld_i,
  input  logic             w_found_i,
  input  logic [L_W-1:0]   w_acc_i,
  input  logic [IDX_W-1:0] w_idx_i,
  input  logic             w_typ_i,
  input  logic [S_W-1:0]   w_start_i,
  input  logic [L_W-1:0]   w_len_i,
  output logic             w_vld_o,
  output logic             w_found_o,
  output logic [L_W-1:0]   w_acc_o,
  output logic [IDX_W-1:0] w_idx_o,
  output logic             w_typ_o,
  output logic [S_W-1:0]   w_start_o,
  output logic [L_W-1:0]   w_len_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);

  logic             typ_q, typ_d;
  logic [S_W-1:0]   start_q, start_d;
  logic [L_W-1:0]   len_q, len_d;
  logic             w_vld_q;
  logic             w_found_q, w_found_d;
  logic [L_W-1:0]   w_acc_q, w_acc_d;
  logic [IDX_W-1:0] w_idx_q, w_idx_d;
  logic             w_typ_q, w_typ_d;
  logic [S_W-1:0]   w_start_q, w_start_d;
  logic [L_W-1:0]   w_len_q, w_len_d;
  logic             active;
  logic [L_W-1:0]   sum;
  logic             hit;

  // Locate: add own length to the running sum, stop at the holding entry
  assign active = (MY_CNT < count_i);
  assign sum    = w_acc_i + len_q;
  assign hit    = w_vld_i && !w_found_i && active && (pos_i < sum);

  always_comb begin
    w_found_d = w_found_i;
    w_acc_d   = w_acc_i;
    w_idx_d   = w_idx_i;
    w_typ_d   = w_typ_i;
    w_start_d = w_start_i;
    w_len_d   = w_len_i;
    if (hit) begin
      w_found_d = 1'b1;
      w_idx_d   = MY_IDX;
      w_typ_d   = typ_q;
      w_start_d = start_q;
      w_len_d   = len_q;
    end else if (!w_found_i && active) begin
      w_acc_d = sum;
    end
  end

  // Entry update: shift from a neighbor or take a written entry
  always_comb begin
    typ_d   = typ_q;
    start_d = start_q;
    len_d   = len_q;
    case (cmd_op_i)
      CMD_SHIFT_UP: begin
        if (MY_IDX > cmd_idx_i) begin
          typ_d   = lo_typ_i;
          start_d = lo_start_i;
          len_d   = lo_len_i;
        end
      end
      CMD_SHIFT_DOWN: begin
        if (MY_IDX >= cmd_idx_i) begin
          typ_d   = hi_typ_i;
          start_d = hi_start_i;
          len_d   = hi_len_i;
        end
      end
      CMD_WRITE: begin
        if (MY_IDX == cmd_idx_i) begin
          typ_d   = cmd_typ_i;
          start_d = cmd_start_i;
          len_d   = cmd_len_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_vld_q <= 1'b0;
    end else begin
      w_vld_q <= w_vld_i;
    end
  end

  // Hold entry and wave payload
  always_ff @(posedge clk_i) begin
    typ_q     <= typ_d;
    start_q   <= start_d;
    len_q     <= len_d;
    w_found_q <= w_found_d;
    w_acc_q   <= w_acc_d;
    w_idx_q   <= w_idx_d;
    w_typ_q   <= w_typ_d;
    w_start_q <= w_start_d;
    w_len_q   <= w_len_d;
  end

  assign typ_o     = typ_q;
  assign start_o   = start_q;
  assign len_o     = len_q;
  assign w_vld_o   = w_vld_q;
  assign w_found_o = w_found_q;
  assign w_acc_o   = w_acc_q;
  assign w_idx_o   = w_idx_q;
  assign w_typ_o   = w_typ_q;
  assign w_start_o = w_start_q;
  assign w_len_o   = w_len_q;

endmodule

// ===== hw/rtl/piece_table_text_editor.sv =====
`timescale 1ns / 1ps
// Piece table editor: controller, MAX_ENTRIES entry cells, two pt_ram buffers; uses pt_pkg.
// A load skips S_SCAN; reads, inserts and deletes run the locate wave in S_SCAN, one cell
// per cycle. S_DECIDE goes to S_EXEC (entry shifts and writes), S_FETCH (read) or S_RESP
// (refused or failed beat); S_EXEC and S_FETCH end in S_RESP. One beat at a time; in_ready_o
// returns with out_valid_o, and a result not yet taken holds the next in S_RESP.
// Reset (rst_ni low, async) clears the entry count and both fill counts.
module piece_table_text_editor import pt_pkg::*; #(
  parameter int MAX_ENTRIES    = 64,
  parameter int ADD_DEPTH      = 4096,
  parameter int ORIGINAL_DEPTH = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        op_i,
  input  logic [POS_W-1:0]  position_i,
  input  logic [CHAR_W-1:0] character_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CHAR_W-1:0] read_char_o,
  output logic [1:0]        status_o
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int OA_W  = $clog2(ORIGINAL_DEPTH);
  localparam int AA_W  = $clog2(ADD_DEPTH);
  localparam int OF_W  = $clog2(ORIGINAL_DEPTH + 1);
  localparam int AF_W  = $clog2(ADD_DEPTH + 1);
  localparam int MAXD  = (ORIGINAL_DEPTH > ADD_DEPTH) ? ORIGINAL_DEPTH : ADD_DEPTH;
  localparam int S_W   = $clog2(MAXD + 1);
  localparam int TXT_W = $clog2(ORIGINAL_DEPTH + ADD_DEPTH + 1);
  localparam int L_W   = (TXT_W > POS_W) ? TXT_W : POS_W;

  // Control state
  state_e            state_q, state_d;
  plan_e             plan_q, plan_d;
  logic [2:0]        step_q, step_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [AF_W-1:0]   afill_q, afill_d;
  logic [OF_W-1:0]   ofill_q, ofill_d;
  logic              edited_q, edited_d;
  logic              start_q;
  logic              out_valid_q, out_valid_d;

  // Beat payload and locate result
  op_e               op_q;
  logic [L_W-1:0]    pos_q;
  logic [CHAR_W-1:0] ch_q;
  logic              res_found_q;
  logic [L_W-1:0]    res_base_q;
  logic [IDX_W-1:0]  res_idx_q;
  logic              res_typ_q;
  logic [S_W-1:0]    res_start_q;
  logic [L_W-1:0]    res_len_q;
  logic [IDX_W-1:0]  tgt_q;
  logic [S_W-1:0]    fresh_q;
  status_e           st_q;
  logic [CHAR_W-1:0] rd_q;
  logic [CHAR_W-1:0] read_char_q;
  logic [1:0]        status_q;

  // Wave links between cells, index 0 fed by the controller
  logic              w_vld   [0:MAX_ENTRIES];
  logic              w_found [0:MAX_ENTRIES];
  logic [L_W-1:0]    w_acc   [0:MAX_ENTRIES];
  logic [IDX_W-1:0]  w_idx   [0:MAX_ENTRIES];
  logic              w_typ   [0:MAX_ENTRIES];
  logic [S_W-1:0]    w_start [0:MAX_ENTRIES];
  logic [L_W-1:0]    w_len   [0:MAX_ENTRIES];
  logic              e_typ   [0:MAX_ENTRIES-1];
  logic [S_W-1:0]    e_start [0:MAX_ENTRIES-1];
  logic [L_W-1:0]    e_len   [0:MAX_ENTRIES-1];

  // Cell command
  cmd_e              cmd_op;
  logic [IDX_W-1:0]  cmd_idx;
  logic              cmd_typ;
  logic [S_W-1:0]    cmd_start;
  logic [L_W-1:0]    cmd_len;

  // Decision terms
  logic [L_W-1:0]    rel;
  logic              rel_zero;
  logic              rel_last;
  logic [CNT_W:0]    cnt_need;
  logic              ins_full;
  plan_e             plan_dec;
  status_e           st_dec;
  logic              exec_last;
  logic [S_W-1:0]    rd_sum;

  // Buffer ports
  logic              o_wr_en, a_wr_en;
  logic [CHAR_W-1:0] o_rd_data, a_rd_data;

  assign w_vld[0]   = start_q;
  assign w_found[0] = 1'b0;
  assign w_acc[0]   = '0;
  assign w_idx[0]   = '0;
  assign w_typ[0]   = BUF_ORIG;
  assign w_start[0] = '0;
  assign w_len[0]   = '0;

  // Chain of entry cells
  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    logic           lo_typ, hi_typ;
    logic [S_W-1:0] lo_start, hi_start;
    logic [L_W-1:0] lo_len, hi_len;

    if (k == 0) begin : g_lo_edge
      assign lo_typ   = BUF_ORIG;
      assign lo_start = '0;
      assign lo_len   = '0;
    end else begin : g_lo
      assign lo_typ   = e_typ[k-1];
      assign lo_start = e_start[k-1];
      assign lo_len   = e_len[k-1];
    end
    if (k == MAX_ENTRIES - 1) begin : g_hi_edge
      assign hi_typ   = BUF_ORIG;
      assign hi_start = '0;
      assign hi_len   = '0;
    end else begin : g_hi
      assign hi_typ   = e_typ[k+1];
      assign hi_start = e_start[k+1];
      assign hi_len   = e_len[k+1];
    end

    pt_cell #(
      .IDX_W(IDX_W), .CNT_W(CNT_W), .S_W(S_W), .L_W(L_W), .INDEX(k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .count_i    (count_q),
      .pos_i      (pos_q),
      .cmd_op_i   (cmd_op),
      .cmd_idx_i  (cmd_idx),
      .cmd_typ_i  (cmd_typ),
      .cmd_start_i(cmd_start),
      .cmd_len_i  (cmd_len),
      .lo_typ_i   (lo_typ),
      .lo_start_i (lo_start),
      .lo_len_i   (lo_len),
      .hi_typ_i   (hi_typ),
      .hi_start_i (hi_start),
      .hi_len_i   (hi_len),
      .typ_o      (e_typ[k]),
      .start_o    (e_start[k]),
      .len_o      (e_len[k]),
      .w_vld_i    (w_vld[k]),
      .w_found_i  (w_found[k]),
      .w_acc_i    (w_acc[k]),
      .w_idx_i    (w_idx[k]),
      .w_typ_i    (w_typ[k]),
      .w_start_i  (w_start[k]),
      .w_len_i    (w_len[k]),
      .w_vld_o    (w_vld[k+1]),
      .w_found_o  (w_found[k+1]),
      .w_acc_o    (w_acc[k+1]),
      .w_idx_o    (w_idx[k+1]),
      .w_typ_o    (w_typ[k+1]),
      .w_start_o  (w_start[k+1]),
      .w_len_o    (w_len[k+1])
    );
  end

  // Offset into the located entry and resource checks
  assign rel      = pos_q - res_base_q;
  assign rel_zero = (rel == '0);
  assign rel_last = (rel == (res_len_q - L_W'(1)));
  assign cnt_need = {1'b0, count_q} +
                    ((res_found_q && !rel_zero) ? (CNT_W+1)'(2) : (CNT_W+1)'(1));
  assign ins_full = (afill_q >= AF_W'(ADD_DEPTH)) ||
                    (cnt_need > (CNT_W+1)'(MAX_ENTRIES));
  assign rd_sum   = res_start_q + rel[S_W-1:0];

  // Choose the edit plan and status of the beat
  always_comb begin
    plan_dec = P_NONE;
    st_dec   = ST_OK;
    case (op_q)
      OP_LOAD: begin
        if (edited_q) begin
          st_dec = ST_REFUSED;
        end else if (ofill_q >= OF_W'(ORIGINAL_DEPTH)) begin
          st_dec = ST_FULL;
        end else begin
          plan_dec = P_LOAD;
        end
      end
      OP_INSERT: begin
        if (ins_full) begin
          st_dec = ST_FULL;
        end else if (!res_found_q) begin
          plan_dec = P_APPEND;
        end else if (rel_zero) begin
          plan_dec = P_FRONT;
        end else begin
          plan_dec = P_SPLIT;
        end
      end
      OP_DELETE: begin
        if (!res_found_q) begin
          st_dec = ST_RANGE;
        end else if (rel_zero) begin
          plan_dec = P_DHEAD;
        end else if (rel_last) begin
          plan_dec = P_DTAIL;
        end else if (count_q >= CNT_W'(MAX_ENTRIES)) begin
          st_dec = ST_FULL;
        end else begin
          plan_dec = P_DSPLIT;
        end
      end
      OP_READ: begin
        if (!res_found_q) begin
          st_dec = ST_RANGE;
        end else begin
          plan_dec = P_READ;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (plan_q)
      P_LOAD, P_APPEND, P_DTAIL: exec_last = 1'b1;
      P_FRONT, P_DHEAD:          exec_last = (step_q == 3'd1);
      P_DSPLIT:                  exec_last = (step_q == 3'd2);
      P_SPLIT:                   exec_last = (step_q == 3'd4);
      default:                   exec_last = 1'b1;
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (op_e'(op_i) == OP_LOAD) ? S_DECIDE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (w_vld[MAX_ENTRIES]) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (plan_dec == P_NONE) begin
          state_d = S_RESP;
        end else if (plan_dec == P_READ) begin
          state_d = S_FETCH;
        end else begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_last) begin
          state_d = S_RESP;
        end
      end
      S_FETCH: state_d = S_RESP;
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs: handshake, buffer writes and cell commands
  always_comb begin
    in_ready_o = (state_q == S_IDLE);
    o_wr_en    = (state_q == S_DECIDE) && (plan_dec == P_LOAD);
    a_wr_en    = (state_q == S_DECIDE) &&
                 ((plan_dec == P_APPEND) || (plan_dec == P_FRONT) ||
                  (plan_dec == P_SPLIT));
    cmd_op     = CMD_NOP;
    cmd_idx    = tgt_q;
    cmd_typ    = res_typ_q;
    cmd_start  = res_start_q;
    cmd_len    = rel;
    if (state_q == S_EXEC) begin
      case (plan_q)
        P_LOAD: begin
          cmd_op    = CMD_WRITE;
          cmd_idx   = '0;
          cmd_typ   = BUF_ORIG;
          cmd_start = '0;
          cmd_len   = L_W'(ofill_q);
        end
        P_APPEND: begin
          cmd_op    = CMD_WRITE;
          cmd_typ   = BUF_ADD;
          cmd_start = fresh_q;
          cmd_len   = L_W'(1);
        end
        P_FRONT: begin
          if (step_q == 3'd0) begin
            cmd_op = CMD_SHIFT_UP;
          end else begin
            cmd_op    = CMD_WRITE;
            cmd_typ   = BUF_ADD;
            cmd_start = fresh_q;
            cmd_len   = L_W'(1);
          end
        end
        P_SPLIT: begin
          case (step_q)
            3'd0, 3'd1: cmd_op = CMD_SHIFT_UP;
            3'd2:       cmd_op = CMD_WRITE;
            3'd3: begin
              cmd_op    = CMD_WRITE;
              cmd_idx   = tgt_q + IDX_W'(1);
              cmd_typ   = BUF_ADD;
              cmd_start = fresh_q;
              cmd_len   = L_W'(1);
            end
            default: begin
              cmd_op    = CMD_WRITE;
              cmd_idx   = tgt_q + IDX_W'(2);
              cmd_start = rd_sum;
              cmd_len   = res_len_q - rel;
            end
          endcase
        end
        P_DHEAD: begin
          if (step_q == 3'd0) begin
            cmd_op    = CMD_WRITE;
            cmd_start = res_start_q + S_W'(1);
            cmd_len   = res_len_q - L_W'(1);
          end else if (res_len_q == L_W'(1)) begin
            cmd_op = CMD_SHIFT_DOWN;
          end
        end
        P_DTAIL: begin
          cmd_op  = CMD_WRITE;
          cmd_len = res_len_q - L_W'(1);
        end
        P_DSPLIT: begin
          case (step_q)
            3'd0: cmd_op = CMD_SHIFT_UP;
            3'd1: cmd_op = CMD_WRITE;
            default: begin
              cmd_op    = CMD_WRITE;
              cmd_idx   = tgt_q + IDX_W'(1);
              cmd_start = rd_sum + S_W'(1);
              cmd_len   = res_len_q - rel - L_W'(1);
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  // Next values of counters and flags
  always_comb begin
    plan_d      = plan_q;
    step_d      = step_q;
    count_d     = count_q;
    afill_d     = afill_q;
    ofill_d     = ofill_q;
    edited_d    = edited_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_DECIDE: begin
        plan_d = plan_dec;
        step_d = '0;
        case (plan_dec)
          P_LOAD: begin
            ofill_d = ofill_q + OF_W'(1);
            count_d = CNT_W'(1);
          end
          P_APPEND, P_FRONT, P_SPLIT: begin
            afill_d  = afill_q + AF_W'(1);
            edited_d = 1'b1;
            count_d  = cnt_need[CNT_W-1:0];
          end
          P_DHEAD: begin
            edited_d = 1'b1;
            if (res_len_q == L_W'(1)) begin
              count_d = count_q - CNT_W'(1);
            end
          end
          P_DTAIL: edited_d = 1'b1;
          P_DSPLIT: begin
            edited_d = 1'b1;
            count_d  = count_q + CNT_W'(1);
          end
          default: begin
          end
        endcase
      end
      S_EXEC: step_d = step_q + 3'd1;
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      plan_q      <= P_NONE;
      step_q      <= '0;
      count_q     <= '0;
      afill_q     <= '0;
      ofill_q     <= '0;
      edited_q    <= 1'b0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      plan_q      <= plan_d;
      step_q      <= step_d;
      count_q     <= count_d;
      afill_q     <= afill_d;
      ofill_q     <= ofill_d;
      edited_q    <= edited_d;
      start_q     <= (state_q == S_IDLE) && in_valid_i && (op_e'(op_i) != OP_LOAD);
      out_valid_q <= out_valid_d;
    end
  end

  // Capture beat, locate result and response payload
  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && in_valid_i) begin
      op_q        <= op_e'(op_i);
      pos_q       <= L_W'(position_i);
      ch_q        <= character_i;
      res_found_q <= 1'b0;
      res_base_q  <= '0;
    end
    if ((state_q == S_SCAN) && w_vld[MAX_ENTRIES]) begin
      res_found_q <= w_found[MAX_ENTRIES];
      res_base_q  <= w_acc[MAX_ENTRIES];
      res_idx_q   <= w_idx[MAX_ENTRIES];
      res_typ_q   <= w_typ[MAX_ENTRIES];
      res_start_q <= w_start[MAX_ENTRIES];
      res_len_q   <= w_len[MAX_ENTRIES];
    end
    if (state_q == S_DECIDE) begin
      st_q    <= st_dec;
      rd_q    <= '0;
      tgt_q   <= res_found_q ? res_idx_q : count_q[IDX_W-1:0];
      fresh_q <= S_W'(afill_q);
    end
    if (state_q == S_FETCH) begin
      rd_q <= (res_typ_q == BUF_ADD) ? a_rd_data : o_rd_data;
    end
    if ((state_q == S_RESP) && (!out_valid_q || out_ready_i)) begin
      read_char_q <= rd_q;
      status_q    <= st_q;
    end
  end

  pt_ram #(.WIDTH(CHAR_W), .DEPTH(ORIGINAL_DEPTH)) u_orig_ram (
    .clk_i    (clk_i),
    .wr_en_i  (o_wr_en),
    .wr_addr_i(ofill_q[OA_W-1:0]),
    .wr_data_i(ch_q),
    .rd_addr_i(rd_sum[OA_W-1:0]),
    .rd_data_o(o_rd_data)
  );

  pt_ram #(.WIDTH(CHAR_W), .DEPTH(ADD_DEPTH)) u_add_ram (
    .clk_i    (clk_i),
    .wr_en_i  (a_wr_en),
    .wr_addr_i(afill_q[AA_W-1:0]),
    .wr_data_i(ch_q),
    .rd_addr_i(rd_sum[AA_W-1:0]),
    .rd_data_o(a_rd_data)
  );

  assign out_valid_o = out_valid_q;
  assign read_char_o = read_char_q;
  assign status_o    = status_q;

endmodule

// ===== hw/rtl/pt_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the piece table editor, bound to the top level.
// Uses pt_pkg.
module pt_checker import pt_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [CHAR_W-1:0] read_char_o,
  input logic [1:0]        status_o
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("stalled result dropped or changed");

  // Drop ready after taking a beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second beat taken while busy");

  // A failed result carries no character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> read_char_o == '0)
    else $error("character on failed result");

  // A new result appears only as the block returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result shown while busy");

endmodule

bind piece_table_text_editor pt_checker u_pt_checker (.*);
